// ===== rtl/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and state-word indexing for the stream cipher unit.
// ----------------------------------------------------------------------------
package cc20_pkg;

    typedef logic [31:0] word_t;
    typedef logic [3:0][31:0] lanes_t;

    // expansion constants for state words 0 to 3
    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0        = 3'd0;
    localparam logic [2:0] REG_KEY1        = 3'd1;
    localparam logic [2:0] REG_KEY2        = 3'd2;
    localparam logic [2:0] REG_KEY3        = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW   = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH  = 3'd5;
    localparam logic [2:0] REG_START_COUNT = 3'd6;

    // quarter-round roles
    localparam logic [1:0] ROLE_A = 2'd0;
    localparam logic [1:0] ROLE_B = 2'd1;
    localparam logic [1:0] ROLE_C = 2'd2;
    localparam logic [1:0] ROLE_D = 2'd3;

    // state word that plays a role in a lane, column or diagonal round
    function automatic logic [3:0] qr_idx(input logic diag, input logic [1:0] lane,
                                          input logic [1:0] role);
        logic [1:0] col;
        col = lane + (diag ? role : 2'd0);
        return {role, col};
    endfunction

endpackage

// ===== rtl/cc20_qr_unit.sv =====
// ----------------------------------------------------------------------------
// cc20_qr_unit
// Four-lane quarter-round step: x += y, z = (z ^ x) rotated left by the step's
// rotation (16, 12, 8, 7).
// ----------------------------------------------------------------------------
module cc20_qr_unit (
    input  cc20_pkg::lanes_t x,
    input  cc20_pkg::lanes_t y,
    input  cc20_pkg::lanes_t z,
    input  logic [1:0]       step,
    output cc20_pkg::lanes_t x_new,
    output cc20_pkg::lanes_t z_new
);
    import cc20_pkg::*;

    lanes_t mix;

    // add, xor and fixed rotation per lane
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            x_new[l] = x[l] + y[l];
            mix[l]   = z[l] ^ x_new[l];
            case (step)
                2'd0:    z_new[l] = {mix[l][15:0], mix[l][31:16]};
                2'd1:    z_new[l] = {mix[l][19:0], mix[l][31:20]};
                2'd2:    z_new[l] = {mix[l][23:0], mix[l][31:24]};
                default: z_new[l] = {mix[l][24:0], mix[l][31:25]};
            endcase
        end
    end

endmodule

// ===== rtl/chacha20_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit
// ChaCha20 (96-bit nonce) stream encrypt/decrypt, up to eight bytes per
// transaction, keystream generated on demand by a shared quarter-round unit.
// ----------------------------------------------------------------------------
// Usage:
//   Key, nonce and start counter are written over the APB port (64-bit data,
//   register i at byte address 8*i) while the unit is idle.
//   Input transactions carry in_data, valid_bytes, first_item and last_item;
//   first_item reloads the block counter and restarts the keystream.
//   One result transaction leaves per input: data XOR keystream, upper
//   unused bytes zero, with copies of the byte count and last mark.
//   For each accepted item the bytes are XORed with the keystream in turn,
//   then the result moves into the output register and the unit returns to
//   idle for the next item. Whenever a new 64-byte keystream block is needed
//   the unit finds it missing, loads the state, runs 80 quarter-round steps
//   on the four-lane unit and does the feed-forward add. in_stall is high
//   from acceptance until the result has moved into the output register.
//   The output register holds a result while out_stall is high; the next item
//   may be accepted and processed meanwhile, and waits in its final state
//   until the register frees.
//   Reset clears the counter, keystream offset and all handshake state; the
//   configuration registers reset to zero.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit #(
    parameter int DOUBLE_ROUNDS = 10,
    parameter int ITEM_BYTES    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] in_data,
    input  logic [3:0]  valid_bytes,
    input  logic        first_item,
    input  logic        last_item,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_data,
    output logic [3:0]  out_valid_bytes,
    output logic        out_last
);
    import cc20_pkg::*;

    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
    localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);
    localparam int ITEM_LIMIT = (ITEM_BYTES < 8) ? ITEM_BYTES : 8;
    localparam logic [3:0] BYTE_LIMIT = 4'(ITEM_LIMIT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BYTES = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FEED  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // configuration registers
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg, start_count_reg;

    // control state
    logic [2:0]      state_reg, state_next;
    logic [31:0]     counter_reg, counter_next;
    logic [5:0]      offset_reg, offset_next;
    logic            ks_ready_reg, ks_ready_next;
    logic [1:0]      step_reg, step_next;
    logic            diag_reg, diag_next;
    logic [DR_W-1:0] dr_reg, dr_next;
    logic [3:0]      byte_idx_reg, byte_idx_next;
    logic [3:0]      n_reg, n_next;
    logic            out_valid_reg, out_valid_next;

    // payload
    word_t       rs_reg [16];
    word_t       rs_next [16];
    word_t       init_w [16];
    logic [63:0] data_reg, data_next;
    logic [63:0] result_reg, result_next;
    logic [3:0]  count_reg, count_next;
    logic        last_reg, last_next;
    logic [63:0] out_data_reg;
    logic [3:0]  out_count_reg;
    logic        out_last_reg;

    logic        cfg_write;
    logic        in_accept;
    logic        out_take;
    logic        out_load;
    logic [3:0]  n_clamped;
    logic [7:0]  ks_byte;
    word_t       ks_word;
    lanes_t      qx, qy, qz, qx_new, qz_new;
    logic [1:0]  role_x, role_y, role_z;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg        <= '0;
            key1_reg        <= '0;
            key2_reg        <= '0;
            key3_reg        <= '0;
            nonce_low_reg   <= '0;
            nonce_high_reg  <= '0;
            start_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                REG_KEY0:        key0_reg        <= pwdata;
                REG_KEY1:        key1_reg        <= pwdata;
                REG_KEY2:        key2_reg        <= pwdata;
                REG_KEY3:        key3_reg        <= pwdata;
                REG_NONCE_LOW:   nonce_low_reg   <= pwdata;
                REG_NONCE_HIGH:  nonce_high_reg  <= pwdata[31:0];
                REG_START_COUNT: start_count_reg <= pwdata[31:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_KEY0:        prdata = key0_reg;
            REG_KEY1:        prdata = key1_reg;
            REG_KEY2:        prdata = key2_reg;
            REG_KEY3:        prdata = key3_reg;
            REG_NONCE_LOW:   prdata = nonce_low_reg;
            REG_NONCE_HIGH:  prdata = {32'd0, nonce_high_reg};
            REG_START_COUNT: prdata = {32'd0, start_count_reg};
            default:         prdata = '0;
        endcase
    end

    // block input words
    always_comb
    begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        init_w[4]  = key0_reg[31:0];
        init_w[5]  = key0_reg[63:32];
        init_w[6]  = key1_reg[31:0];
        init_w[7]  = key1_reg[63:32];
        init_w[8]  = key2_reg[31:0];
        init_w[9]  = key2_reg[63:32];
        init_w[10] = key3_reg[31:0];
        init_w[11] = key3_reg[63:32];
        init_w[12] = counter_reg;
        init_w[13] = nonce_low_reg[31:0];
        init_w[14] = nonce_low_reg[63:32];
        init_w[15] = nonce_high_reg;
    end

    // operand selection for the shared quarter-round unit
    assign role_x = step_reg[0] ? ROLE_C : ROLE_A;
    assign role_y = step_reg[0] ? ROLE_D : ROLE_B;
    assign role_z = step_reg[0] ? ROLE_B : ROLE_D;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            qx[l] = rs_reg[qr_idx(diag_reg, 2'(l), role_x)];
            qy[l] = rs_reg[qr_idx(diag_reg, 2'(l), role_y)];
            qz[l] = rs_reg[qr_idx(diag_reg, 2'(l), role_z)];
        end
    end

    cc20_qr_unit u_qr (
        .x     (qx),
        .y     (qy),
        .z     (qz),
        .step  (step_reg),
        .x_new (qx_new),
        .z_new (qz_new)
    );

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign n_clamped = (valid_bytes > BYTE_LIMIT) ? BYTE_LIMIT : valid_bytes;

    // keystream byte at the current offset
    assign ks_word = rs_reg[offset_reg[5:2]];
    assign ks_byte = ks_word[8*offset_reg[1:0] +: 8];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        offset_next    = offset_reg;
        ks_ready_next  = ks_ready_reg;
        step_next      = step_reg;
        diag_next      = diag_reg;
        dr_next        = dr_reg;
        byte_idx_next  = byte_idx_reg;
        n_next         = n_reg;
        data_next      = data_reg;
        result_next    = result_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 16; i++)
        begin
            rs_next[i] = rs_reg[i];
        end

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    data_next     = in_data;
                    count_next    = valid_bytes;
                    last_next     = last_item;
                    n_next        = n_clamped;
                    byte_idx_next = '0;
                    result_next   = '0;
                    if (first_item)
                    begin
                        counter_next  = start_count_reg;
                        offset_next   = '0;
                        ks_ready_next = 1'b0;
                    end
                    state_next = ST_BYTES;
                end
            end
            ST_BYTES:
            begin
                if (byte_idx_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!ks_ready_reg)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    result_next[8*byte_idx_reg[2:0] +: 8] =
                        data_reg[8*byte_idx_reg[2:0] +: 8] ^ ks_byte;
                    byte_idx_next = byte_idx_reg + 4'd1;
                    offset_next   = offset_reg + 6'd1;
                    if (offset_reg == 6'd63)
                    begin
                        ks_ready_next = 1'b0;
                    end
                end
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    rs_next[i] = init_w[i];
                end
                step_next  = '0;
                diag_next  = 1'b0;
                dr_next    = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    rs_next[qr_idx(diag_reg, 2'(l), role_x)] = qx_new[l];
                    rs_next[qr_idx(diag_reg, 2'(l), role_z)] = qz_new[l];
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    diag_next = ~diag_reg;
                    if (diag_reg)
                    begin
                        if (dr_reg == DR_LAST)
                        begin
                            state_next = ST_FEED;
                        end
                        else
                        begin
                            dr_next = dr_reg + DR_W'(1);
                        end
                    end
                end
            end
            ST_FEED:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    rs_next[i] = rs_reg[i] + init_w[i];
                end
                counter_next  = counter_reg + 32'd1;
                ks_ready_next = 1'b1;
                state_next    = ST_BYTES;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            offset_reg    <= '0;
            ks_ready_reg  <= 1'b0;
            step_reg      <= '0;
            diag_reg      <= 1'b0;
            dr_reg        <= '0;
            byte_idx_reg  <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            offset_reg    <= offset_next;
            ks_ready_reg  <= ks_ready_next;
            step_reg      <= step_next;
            diag_reg      <= diag_next;
            dr_reg        <= dr_next;
            byte_idx_reg  <= byte_idx_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            rs_reg[i] <= rs_next[i];
        end
        data_reg   <= data_next;
        result_reg <= result_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
        if (out_load)
        begin
            out_data_reg  <= result_reg;
            out_count_reg <= count_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_valid_bytes = out_count_reg;
    assign out_last        = out_last_reg;

    // checks
    a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_BYTES))
        else $error("accepted transaction did not start byte processing");

    a_feed_gives_keystream: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FEED) |=> (ks_ready_reg && state_reg == ST_BYTES))
        else $error("feed-forward did not leave a ready keystream block");

    a_byte_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BYTES) |-> (byte_idx_reg <= n_reg && n_reg <= 4'd8))
        else $error("byte index ran past the item byte count");

    a_round_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (dr_reg <= DR_LAST))
        else $error("double-round counter out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result was overwritten");

endmodule

// ===== verif/chacha20_stream_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_checker
// Scoreboard for the stream cipher unit. Follows APB writes to keep its own
// copy of key, nonce and start counter, computes the keystream for every
// accepted input transaction and compares output transactions in order.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    // input channel
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] in_data,
    input  logic [3:0]  valid_bytes,
    input  logic        first_item,
    input  logic        last_item,
    // output channel
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] out_data,
    input  logic [3:0]  out_valid_bytes,
    input  logic        out_last,
    // status for the top
    output int unsigned mismatch_count,
    output int unsigned results_pending
);
    import cc20_pkg::*;

    localparam int DOUBLE_ROUNDS  = 10;
    localparam int MAX_ITEM_BYTES = 8;

    typedef logic [15:0][31:0] cc_block_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        is_last;
    } cipher_result_t;

    cipher_result_t expected_q[$];
    cipher_result_t oldest;

    // configuration copy
    word_t key_words [8];
    word_t nonce_words [3];
    word_t start_count;

    // stream position
    word_t      blk_counter;
    logic [5:0] byte_pos;
    logic       ks_ready;
    cc_block_t  ks_words;

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic cc_block_t quarter_mix(input cc_block_t w, input int a, input int b,
                                              input int c, input int d);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
        return w;
    endfunction

    // one 64-byte keystream block for the given counter
    function automatic cc_block_t chacha_block(input word_t ctr);
        cc_block_t init_w;
        cc_block_t w;
        int        j;
        init_w[0] = SIGMA0;
        init_w[1] = SIGMA1;
        init_w[2] = SIGMA2;
        init_w[3] = SIGMA3;
        for (j = 0; j < 8; j++)
            init_w[4 + j] = key_words[j];
        init_w[12] = ctr;
        init_w[13] = nonce_words[0];
        init_w[14] = nonce_words[1];
        init_w[15] = nonce_words[2];
        w = init_w;
        for (j = 0; j < DOUBLE_ROUNDS; j++)
        begin
            // column round
            w = quarter_mix(w, 0, 4, 8, 12);
            w = quarter_mix(w, 1, 5, 9, 13);
            w = quarter_mix(w, 2, 6, 10, 14);
            w = quarter_mix(w, 3, 7, 11, 15);
            // diagonal round
            w = quarter_mix(w, 0, 5, 10, 15);
            w = quarter_mix(w, 1, 6, 11, 12);
            w = quarter_mix(w, 2, 7, 8, 13);
            w = quarter_mix(w, 3, 4, 9, 14);
        end
        // feed-forward add
        for (j = 0; j < 16; j++)
            w[j] = w[j] + init_w[j];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // keystream xor for one input transaction, queued as the expected result
    task automatic encrypt_item(input logic [63:0] din, input logic [3:0] cnt,
                                input logic is_first, input logic is_last);
        cipher_result_t res;
        int             nproc;
        int             i;
        logic [7:0]     ks_byte;
        res.data    = '0;
        res.nbytes  = cnt;
        res.is_last = is_last;
        // restart: reload counter, drop any keystream in hand
        if (is_first)
        begin
            blk_counter = start_count;
            byte_pos    = '0;
            ks_ready    = 1'b0;
        end
        nproc = (cnt > MAX_ITEM_BYTES) ? MAX_ITEM_BYTES : int'(cnt);
        for (i = 0; i < nproc; i++)
        begin
            if (!ks_ready)
            begin
                ks_words    = chacha_block(blk_counter);
                blk_counter = blk_counter + 1;
                ks_ready    = 1'b1;
            end
            ks_byte = ks_words[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8];
            res.data[8*i +: 8] = din[8*i +: 8] ^ ks_byte;
            byte_pos = byte_pos + 1'b1;
            if (byte_pos == 6'd0)
                ks_ready = 1'b0;
        end
        expected_q.push_back(res);
    endtask

    // watch configuration writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (key_words[k])
                key_words[k] = '0;
            foreach (nonce_words[k])
                nonce_words[k] = '0;
            start_count     = '0;
            blk_counter     = '0;
            byte_pos        = '0;
            ks_ready        = 1'b0;
            ks_words        = '0;
            expected_q.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_KEY0:
                    begin
                        key_words[0] = pwdata[31:0];
                        key_words[1] = pwdata[63:32];
                    end
                    REG_KEY1:
                    begin
                        key_words[2] = pwdata[31:0];
                        key_words[3] = pwdata[63:32];
                    end
                    REG_KEY2:
                    begin
                        key_words[4] = pwdata[31:0];
                        key_words[5] = pwdata[63:32];
                    end
                    REG_KEY3:
                    begin
                        key_words[6] = pwdata[31:0];
                        key_words[7] = pwdata[63:32];
                    end
                    REG_NONCE_LOW:
                    begin
                        nonce_words[0] = pwdata[31:0];
                        nonce_words[1] = pwdata[63:32];
                    end
                    REG_NONCE_HIGH:  nonce_words[2] = pwdata[31:0];
                    REG_START_COUNT: start_count    = pwdata[31:0];
                    default: ;
                endcase
            end
            // output transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected output transaction", out_data, 64'h0);
                else
                begin
                    oldest = expected_q.pop_front();
                    if (out_data !== oldest.data)
                        report_mismatch("out_data", out_data, oldest.data);
                    if (out_valid_bytes !== oldest.nbytes)
                        report_mismatch("out_valid_bytes", 64'(out_valid_bytes),
                                        64'(oldest.nbytes));
                    if (out_last !== oldest.is_last)
                        report_mismatch("out_last", 64'(out_last), 64'(oldest.is_last));
                end
            end
            // input transaction
            if (in_valid && !in_stall)
                encrypt_item(in_data, valid_bytes, first_item, last_item);
            results_pending = expected_q.size();
        end
    end

endmodule

// ===== verif/tb_chacha20_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher_unit
// Stimulus and verdict for the stream cipher unit: programs key, nonce and
// start counter over APB between phases, sends directed and random messages
// with bursty input and a stalling receiver, and leaves checking to the
// scoreboard beside the unit.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_unit;
    import cc20_pkg::*;

    localparam int ITEM_TARGET     = 850;
    localparam int PHASE_ITEMS     = 110;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 20;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [5:0]  paddr       = '0;
    logic [63:0] pwdata      = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [63:0] in_data     = '0;
    logic [3:0]  valid_bytes = 4'd8;
    logic        first_item  = 1'b0;
    logic        last_item   = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [63:0] out_data;
    logic [3:0]  out_valid_bytes;
    logic        out_last;

    int unsigned mismatch_count;
    int unsigned results_pending;

    int   items_sent   = 0;
    int   burst_left   = 0;
    int   idle_cycles  = 0;
    int   stall_mode   = 0;
    int   mode_left    = 0;
    logic hold_trigger = 1'b0;
    logic hold_off     = 1'b0;

    chacha20_stream_cipher_unit u_dut (.*);

    chacha20_stream_cipher_checker u_checker (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // apb write: setup phase, access phase, then the bus goes idle
    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_config(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3,
                                  input logic [63:0] nlow, input logic [63:0] nhigh,
                                  input logic [63:0] ctr);
        apb_write(REG_KEY0, k0);
        apb_write(REG_KEY1, k1);
        apb_write(REG_KEY2, k2);
        apb_write(REG_KEY3, k3);
        apb_write(REG_NONCE_LOW, nlow);
        apb_write(REG_NONCE_HIGH, nhigh);
        apb_write(REG_START_COUNT, ctr);
    endtask

    // one input transaction, with bursts and random gaps between them
    task automatic send_item(input logic [63:0] data, input logic [3:0] cnt,
                             input logic is_first, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        in_valid    <= 1'b1;
        in_data     <= data;
        valid_bytes <= cnt;
        first_item  <= is_first;
        last_item   <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // well-formed message: full items, last one of 1 to 8 bytes
    task automatic send_message(input int n_items);
        int         k;
        logic [3:0] cnt;
        for (k = 0; k < n_items; k++)
        begin
            cnt = (k == n_items - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
            send_item(rand64(), cnt, k == 0, k == n_items - 1);
        end
    endtask

    // stop sending and wait for every expected result
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver stall pattern, switching mode now and then
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 4);
                mode_left  <= $urandom_range(32, 256);
            end
            else
                mode_left <= mode_left - 1;
            if (hold_off)
                out_stall <= 1'b1;
            else
            begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= 1'($urandom_range(0, 1));
                    3:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // long receiver hold-off so the unit backs up into its input
    initial
    begin
        wait (hold_trigger);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable && pready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial
    begin
        int          phase_no;
        int          phase_start;
        int          k;
        logic [31:0] ctr_low;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: standard key 00..1f, nonce with only byte 7 set to 4a, counter 1
        program_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                       64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                       64'h4a00000000000000, 64'h0, 64'h1);
        send_item(64'h0, 4'd8, 1'b1, 1'b0);
        send_item('1, 4'd8, 1'b0, 1'b0);
        // zero count processes nothing
        send_item(rand64(), 4'd0, 1'b0, 1'b0);
        // oversized counts are clamped
        send_item(rand64(), 4'd15, 1'b0, 1'b0);
        send_item(rand64(), 4'd9, 1'b0, 1'b0);
        // short item that is not the last
        send_item(rand64(), 4'd3, 1'b0, 1'b0);
        send_item('1, 4'd1, 1'b0, 1'b0);
        // run across a block boundary
        for (k = 0; k < 8; k++)
            send_item(k[0] ? 64'haaaaaaaaaaaaaaaa : 64'h5555555555555555, 4'd8, 1'b0, 1'b0);
        send_item(rand64(), 4'd5, 1'b0, 1'b1);
        // keystream continues after the last mark
        send_item(rand64(), 4'd8, 1'b0, 1'b0);
        send_item(rand64(), 4'd8, 1'b0, 1'b0);
        // single-item message
        send_item(rand64(), 4'd7, 1'b1, 1'b1);
        finish_phase();

        // random phases, each with its own configuration
        phase_no = 1;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase_no)
                // all ones, counter wraps after the first block
                1: program_config('1, '1, '1, '1, '1, '1, '1);
                2: program_config('0, '0, '0, '0, '0, '0, '0);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       ctr_low = 32'hffffffff - $urandom_range(0, 3);
                        1:       ctr_low = 32'h0;
                        default: ctr_low = $urandom;
                    endcase
                    program_config(rand64(), rand64(), rand64(), rand64(), rand64(),
                                   rand64(), {$urandom, ctr_low});
                end
            endcase
            phase_start = items_sent;
            if (phase_no == 3)
                hold_trigger = 1'b1;
            // carry on the previous stream under the new settings
            if (phase_no >= 3 && $urandom_range(0, 2) == 0)
            begin
                send_item(rand64(), 4'd8, 1'b0, 1'b0);
                send_item(rand64(), 4'($urandom_range(1, 8)), 1'b0, 1'b0);
            end
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_item(rand64(), 4'($urandom_range(0, 15)),
                              $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
                else
                    send_message(($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                              : $urandom_range(1, 10));
            end
            finish_phase();
            phase_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
